// File: sv/radial_spotlight_luminance_defines.svh
// assertion macros for the radial spotlight luminance block
// no dependencies; expects clk and rst_n in the scope of each use
`ifndef RADIAL_SPOTLIGHT_LUMINANCE_DEFINES_SVH
`define RADIAL_SPOTLIGHT_LUMINANCE_DEFINES_SVH
`ifndef SYNTH
`define RSL_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rsl same-cycle check failed");
`define RSL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rsl next-cycle check failed");
`else
`define RSL_ASSERT_IMPL(label, ante, cons)
`define RSL_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: sv/rsl_pkg.sv
// shared constants and types for the radial spotlight luminance block
// no dependencies
package rsl_pkg;

    localparam int CENTER_BITS     = 14;
    localparam int COORD_BITS_DEF  = 12;
    localparam int LUM_BITS_DEF    = 16;

    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X = 1'b0,
        REG_CENTER_Y = 1'b1
    } cfg_reg_t;

    // falloff radius is 200 px, 51200 in q8; squared radius in px is 40000
    localparam int FALLOFF_W     = 16;
    localparam int FALLOFF_Q8    = 51200;
    localparam int FAR_SQ        = 40000;
    // 51200 = 25 << 11
    localparam int FALLOFF_SHIFT = 11;
    localparam int FALLOFF_ODD   = 25;
    localparam int ODD_LOG2      = 5;

    // square root of a 32 bit radicand, 16 root bits, 4 per stage
    localparam int RAD_W           = 32;
    localparam int ROOT_BITS       = 16;
    localparam int ROOT_PER_STAGE  = 4;
    localparam int ROOT_STAGES     = ROOT_BITS / ROOT_PER_STAGE;

endpackage

// File: sv/rsl_root_stage.sv
// one registered stage of the square root pipeline, several root bits per stage
// depends on rsl_pkg
module rsl_root_stage
    import rsl_pkg::*;
#(
    parameter int FIRST  = 0,
    parameter int SIDE_W = LUM_BITS_DEF + 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [RAD_W-1:0]  in_rem,
    input  logic [RAD_W-1:0]  in_root,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [RAD_W-1:0]  out_rem,
    output logic [RAD_W-1:0]  out_root,
    output logic [SIDE_W-1:0] out_side
);

    logic              valid_reg;
    logic [RAD_W-1:0]  rem_reg;
    logic [RAD_W-1:0]  root_reg;
    logic [SIDE_W-1:0] side_reg;
    logic [RAD_W-1:0]  rem_next;
    logic [RAD_W-1:0]  root_next;
    logic [RAD_W:0]    trial;
    logic [RAD_W:0]    bitv;

    // restoring root: compare remainder against root plus the current bit
    always_comb
    begin
        rem_next  = in_rem;
        root_next = in_root;
        trial     = '0;
        bitv      = '0;
        for (int k = 0; k < ROOT_PER_STAGE; k++)
        begin
            bitv  = (RAD_W+1)'(1) << (RAD_W - 2 - 2 * (FIRST + k));
            trial = {1'b0, root_next} + bitv;
            if ({1'b0, rem_next} >= trial)
            begin
                rem_next  = rem_next - trial[RAD_W-1:0];
                root_next = (root_next >> 1) + bitv[RAD_W-1:0];
            end
            else
            begin
                root_next = root_next >> 1;
            end
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_root  = root_reg;
    assign out_side  = side_reg;

endmodule

// File: sv/radial_spotlight_luminance.sv
// Radial spotlight luminance falloff.
// Input channel in_valid/in_ready carries one pixel per beat: pixel_x, pixel_y
// and lum_in. Output channel out_valid/out_ready carries lum_out, one beat for
// every input beat, in order. Config channel cfg_valid/cfg_ready writes the
// spotlight center (cfg_index selects center_x or center_y); cfg_ready is
// always high, and the center should only change while no pixel is in flight.
// Throughput: one pixel per clock while out_ready is high. The 16-bit root is
// resolved four bits per stage, which with the square, divide and handshake
// stages gives 11 register stages. Reset clears every valid bit and sets the
// center to (0, 0); payload registers are not reset.
// When the receiver stalls, the pipeline keeps moving until the first valid
// stage that cannot advance; bubbles are squeezed out, so new pixels are still
// taken while a finished result waits. in_ready drops only once every stage is
// full. Nothing is lost or repeated across a stall.
// Distance: d_q = floor(sqrt(sq << 16)); anything with sq >= 40000 lies at or
// beyond 200 px and gives zero. Final divide by 51200 is a shift by 11 and an
// exact reciprocal multiply by 1/25.
`include "radial_spotlight_luminance_defines.svh"
module radial_spotlight_luminance
    import rsl_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int LUM_BITS   = LUM_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // config channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CENTER_BITS-1:0] cfg_data,
    // pixel input
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [COORD_BITS-1:0]  pixel_x,
    input  logic [COORD_BITS-1:0]  pixel_y,
    input  logic [LUM_BITS-1:0]    lum_in,
    // result output
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [LUM_BITS-1:0]    lum_out
);

    // difference width: enough for pixel minus a negative center
    localparam int DW     = ((COORD_BITS > CENTER_BITS) ? COORD_BITS : CENTER_BITS) + 2;
    localparam int AW     = DW - 1;
    localparam int SQ_W   = 2 * AW;
    localparam int SUM_W  = SQ_W + 1;
    localparam int HALF_W = RAD_W / 2;
    localparam int SIDE_W = LUM_BITS + 1;
    // product and exact reciprocal for the divide by 25
    localparam int PROD_W = LUM_BITS + FALLOFF_W;
    localparam int Q1_W   = LUM_BITS + ODD_LOG2;
    localparam int K      = Q1_W + ODD_LOG2;
    localparam int M_W    = K - 4;
    localparam logic [63:0] M_FULL = ((64'd1 << K) + 64'(FALLOFF_ODD - 1)) / 64'(FALLOFF_ODD);
    localparam logic [M_W-1:0] DIV_MUL = M_FULL[M_W-1:0];
    localparam int QT_W   = Q1_W + M_W;

    // ---------------- config registers ----------------
    logic [CENTER_BITS-1:0] center_x_reg;
    logic [CENTER_BITS-1:0] center_y_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_CENTER_X: center_x_reg <= cfg_data;
                REG_CENTER_Y: center_y_reg <= cfg_data;
            endcase
        end
    end

    // ---------------- ready chain ----------------
    // each stage loads when empty or when the stage after it loads
    logic s0_valid_reg, s1_valid_reg, s2_valid_reg;
    logic s7_valid_reg, s8_valid_reg, s9_valid_reg, s10_valid_reg;
    logic rdy0, rdy1, rdy2, rdy7, rdy8, rdy9, rdy10;
    logic root_in_ready;

    assign rdy10    = !s10_valid_reg || out_ready;
    assign rdy9     = !s9_valid_reg  || rdy10;
    assign rdy8     = !s8_valid_reg  || rdy9;
    assign rdy7     = !s7_valid_reg  || rdy8;
    assign rdy2     = !s2_valid_reg  || root_in_ready;
    assign rdy1     = !s1_valid_reg  || rdy2;
    assign rdy0     = !s0_valid_reg  || rdy1;
    assign in_ready = rdy0;

    // ---------------- stage 0: signed differences, magnitudes ----------------
    logic signed [DW-1:0] dx, dy;
    logic [DW-1:0]        ndx, ndy;
    logic [AW-1:0]        adx_next, ady_next;
    logic [AW-1:0]        s0_adx_reg, s0_ady_reg;
    logic [LUM_BITS-1:0]  s0_lum_reg;

    always_comb
    begin
        dx  = $signed({{(DW-COORD_BITS){1'b0}}, pixel_x})
            - $signed({{(DW-CENTER_BITS){center_x_reg[CENTER_BITS-1]}}, center_x_reg});
        dy  = $signed({{(DW-COORD_BITS){1'b0}}, pixel_y})
            - $signed({{(DW-CENTER_BITS){center_y_reg[CENTER_BITS-1]}}, center_y_reg});
        ndx = -dx;
        ndy = -dy;
        adx_next = dx[DW-1] ? ndx[AW-1:0] : dx[AW-1:0];
        ady_next = dy[DW-1] ? ndy[AW-1:0] : dy[AW-1:0];
    end

    // ---------------- stage 1: squares ----------------
    logic [SQ_W-1:0]     s1_sqx_reg, s1_sqy_reg;
    logic [LUM_BITS-1:0] s1_lum_reg;

    // ---------------- stage 2: sum, range test, radicand ----------------
    logic [SUM_W-1:0]    sum;
    logic                far_next;
    logic [RAD_W-1:0]    rad_next;
    logic [RAD_W-1:0]    s2_rad_reg;
    logic                s2_far_reg;
    logic [LUM_BITS-1:0] s2_lum_reg;

    always_comb
    begin
        sum      = SUM_W'(s1_sqx_reg) + SUM_W'(s1_sqy_reg);
        far_next = (sum >= SUM_W'(FAR_SQ));
        // below the radius the sum fits in HALF_W bits, which form the upper half of the radicand
        rad_next = far_next ? '0 : {sum[HALF_W-1:0], {HALF_W{1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy0)
            begin
                s0_valid_reg <= in_valid;
            end
            if (rdy1)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
            if (rdy2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy0)
        begin
            s0_adx_reg <= adx_next;
            s0_ady_reg <= ady_next;
            s0_lum_reg <= lum_in;
        end
        if (rdy1)
        begin
            s1_sqx_reg <= SQ_W'(s0_adx_reg) * SQ_W'(s0_adx_reg);
            s1_sqy_reg <= SQ_W'(s0_ady_reg) * SQ_W'(s0_ady_reg);
            s1_lum_reg <= s0_lum_reg;
        end
        if (rdy2)
        begin
            s2_rad_reg <= rad_next;
            s2_far_reg <= far_next;
            s2_lum_reg <= s1_lum_reg;
        end
    end

    // ---------------- stages 3..6: square root ----------------
    logic              root_valid [0:ROOT_STAGES];
    logic              root_ready [0:ROOT_STAGES];
    logic [RAD_W-1:0]  root_rem   [0:ROOT_STAGES];
    logic [RAD_W-1:0]  root_val   [0:ROOT_STAGES];
    logic [SIDE_W-1:0] root_side  [0:ROOT_STAGES];

    assign root_valid[0]            = s2_valid_reg;
    assign root_rem[0]              = s2_rad_reg;
    assign root_val[0]              = '0;
    assign root_side[0]             = {s2_far_reg, s2_lum_reg};
    assign root_in_ready            = root_ready[0];
    assign root_ready[ROOT_STAGES]  = rdy7;

    for (genvar g = 0; g < ROOT_STAGES; g++)
    begin : g_root
        rsl_root_stage #(
            .FIRST  (g * ROOT_PER_STAGE),
            .SIDE_W (SIDE_W)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (root_valid[g]),
            .in_ready  (root_ready[g]),
            .in_rem    (root_rem[g]),
            .in_root   (root_val[g]),
            .in_side   (root_side[g]),
            .out_valid (root_valid[g+1]),
            .out_ready (root_ready[g+1]),
            .out_rem   (root_rem[g+1]),
            .out_root  (root_val[g+1]),
            .out_side  (root_side[g+1])
        );
    end

    // ---------------- stage 7: falloff factor ----------------
    logic                 root_far;
    logic [LUM_BITS-1:0]  root_lum;
    logic [FALLOFF_W-1:0] d_q;
    logic [FALLOFF_W-1:0] factor_next;
    logic [FALLOFF_W-1:0] s7_factor_reg;
    logic [LUM_BITS-1:0]  s7_lum_reg;

    always_comb
    begin
        root_far    = root_side[ROOT_STAGES][SIDE_W-1];
        root_lum    = root_side[ROOT_STAGES][LUM_BITS-1:0];
        d_q         = root_val[ROOT_STAGES][FALLOFF_W-1:0];
        factor_next = root_far ? '0 : (FALLOFF_W'(FALLOFF_Q8) - d_q);
    end

    // ---------------- stage 8: luminance times factor ----------------
    logic [PROD_W-1:0] s8_prod_reg;

    // ---------------- stage 9: divide by 2^11, multiply by 1/25 ----------------
    logic [Q1_W-1:0]   q1;
    logic [QT_W-1:0]   s9_quot_reg;

    assign q1 = s8_prod_reg[FALLOFF_SHIFT +: Q1_W];

    // ---------------- stage 10: output register ----------------
    logic [LUM_BITS-1:0] s10_lum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s7_valid_reg  <= 1'b0;
            s8_valid_reg  <= 1'b0;
            s9_valid_reg  <= 1'b0;
            s10_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy7)
            begin
                s7_valid_reg <= root_valid[ROOT_STAGES];
            end
            if (rdy8)
            begin
                s8_valid_reg <= s7_valid_reg;
            end
            if (rdy9)
            begin
                s9_valid_reg <= s8_valid_reg;
            end
            if (rdy10)
            begin
                s10_valid_reg <= s9_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy7)
        begin
            s7_factor_reg <= factor_next;
            s7_lum_reg    <= root_lum;
        end
        if (rdy8)
        begin
            s8_prod_reg <= PROD_W'(s7_lum_reg) * PROD_W'(s7_factor_reg);
        end
        if (rdy9)
        begin
            s9_quot_reg <= QT_W'(q1) * QT_W'(DIV_MUL);
        end
        if (rdy10)
        begin
            s10_lum_reg <= s9_quot_reg[K +: LUM_BITS];
        end
    end

    assign out_valid = s10_valid_reg;
    assign lum_out   = s10_lum_reg;

    // ---------------- checks ----------------
    // input back-pressure only ever comes from a stalled, full output
    `RSL_ASSERT_IMPL(a_stall_source, !in_ready, out_valid && !out_ready)
    // a pixel beyond the radius leaves the factor stage with a zero factor
    `RSL_ASSERT_NEXT(a_far_factor, rdy7 && root_valid[ROOT_STAGES] && root_far, s7_factor_reg == '0)
    // inside the radius the root never reaches the falloff distance
    `RSL_ASSERT_IMPL(a_root_range, root_valid[ROOT_STAGES] && !root_far, d_q < FALLOFF_W'(FALLOFF_Q8))

endmodule
